>>> design/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg: shared codes for the rational arithmetic unit
// Operation modes, status codes and compare outcomes used on the ports.
// ----------------------------------------------------------------------------
package rau_pkg;

   localparam logic [2:0] MODE_ADD = 3'd0;
   localparam logic [2:0] MODE_SUB = 3'd1;
   localparam logic [2:0] MODE_MUL = 3'd2;
   localparam logic [2:0] MODE_DIV = 3'd3;
   localparam logic [2:0] MODE_CMP = 3'd4;

   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_DIV_ZERO = 2'd1;
   localparam logic [1:0] STAT_DEN_ZERO = 2'd2;

   localparam logic [1:0] ORD_EQUAL   = 2'd0;
   localparam logic [1:0] ORD_GREATER = 2'd1;
   localparam logic [1:0] ORD_LESS    = 2'd2;

endpackage

>>> design/rau_mult.sv
// ----------------------------------------------------------------------------
// rau_mult: registered unsigned multiplier
// One product per cycle, available on the cycle after the operands.
// ----------------------------------------------------------------------------
module rau_mult #(
   parameter int unsigned WIDTH = 16
) (
   input  logic                 clock,
   input  logic [WIDTH-1:0]     op_a,
   input  logic [WIDTH-1:0]     op_b,
   output logic [2*WIDTH-1:0]   prod
);

   logic [2*WIDTH-1:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= {{WIDTH{1'b0}}, op_a} * {{WIDTH{1'b0}}, op_b};
   end

   assign prod = prod_ff;

endmodule

>>> design/rau_reduce.sv
// ----------------------------------------------------------------------------
// rau_reduce: fraction reduction engine
// Finds the greatest common divisor of two magnitudes with a binary GCD and
// then divides both by it with a restoring divider. A single subtractor is
// shared by the GCD steps and the division steps.
// ----------------------------------------------------------------------------
module rau_reduce #(
   parameter int unsigned NW = 32
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [NW-1:0]   num_mag,
   input  logic [NW-1:0]   den_mag,
   output logic            done,
   output logic [NW-1:0]   q_num,
   output logic [NW-1:0]   q_den
);

   localparam int unsigned CW = $clog2(NW);

   localparam logic [1:0] R_IDLE = 2'd0;
   localparam logic [1:0] R_GCD  = 2'd1;
   localparam logic [1:0] R_DIVN = 2'd2;
   localparam logic [1:0] R_DIVD = 2'd3;

   logic [1:0]    state_ff, state_in;
   logic          done_ff, done_in;
   logic [NW-1:0] u_ff, u_in;
   logic [NW-1:0] v_ff, v_in;
   logic [NW-1:0] g_ff, g_in;
   logic [NW-1:0] n_ff, n_in;
   logic [NW-1:0] d_ff, d_in;
   logic [NW-1:0] quo_ff, quo_in;
   logic [NW-1:0] rem_ff, rem_in;
   logic [NW-1:0] qn_ff, qn_in;
   logic [NW-1:0] qd_ff, qd_in;
   logic [CW-1:0] k_ff, k_in;
   logic [CW-1:0] cnt_ff, cnt_in;

   // Shared subtractor; the top bit of the difference is the borrow.
   logic [NW:0]   sub_a, sub_b;
   logic [NW+1:0] sub_diff;
   logic          borrow;
   logic [NW-1:0] quo_shift;

   always_comb begin
      if (state_ff == R_GCD) begin
         sub_a = {1'b0, u_ff};
         sub_b = {1'b0, v_ff};
      end else begin
         sub_a = {rem_ff, quo_ff[NW-1]};
         sub_b = {1'b0, g_ff};
      end
   end

   assign sub_diff  = {1'b0, sub_a} - {1'b0, sub_b};
   assign borrow    = sub_diff[NW+1];
   assign quo_shift = {quo_ff[NW-2:0], ~borrow};

   always_comb begin
      state_in = state_ff;
      done_in  = 1'b0;
      u_in     = u_ff;
      v_in     = v_ff;
      g_in     = g_ff;
      n_in     = n_ff;
      d_in     = d_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      qn_in    = qn_ff;
      qd_in    = qd_ff;
      k_in     = k_ff;
      cnt_in   = cnt_ff;

      unique case (state_ff)
         R_IDLE: begin
            if (start) begin
               n_in = num_mag;
               d_in = den_mag;
               if (num_mag == '0) begin
                  // A zero numerator always reduces to 0/1.
                  qn_in   = '0;
                  qd_in   = NW'(1);
                  done_in = 1'b1;
               end else begin
                  u_in     = num_mag;
                  v_in     = den_mag;
                  k_in     = '0;
                  state_in = R_GCD;
               end
            end
         end
         R_GCD: begin
            if (u_ff == '0) begin
               g_in     = v_ff << k_ff;
               quo_in   = n_ff;
               rem_in   = '0;
               cnt_in   = CW'(NW - 1);
               state_in = R_DIVN;
            end else if (!u_ff[0] && !v_ff[0]) begin
               u_in = u_ff >> 1;
               v_in = v_ff >> 1;
               k_in = k_ff + 1'b1;
            end else if (!u_ff[0]) begin
               u_in = u_ff >> 1;
            end else if (!v_ff[0]) begin
               v_in = v_ff >> 1;
            end else if (!borrow) begin
               // Both odd: the difference is even, so it halves exactly.
               u_in = {1'b0, sub_diff[NW-1:1]};
            end else begin
               u_in = v_ff;
               v_in = u_ff;
            end
         end
         R_DIVN, R_DIVD: begin
            rem_in = borrow ? sub_a[NW-1:0] : sub_diff[NW-1:0];
            quo_in = quo_shift;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               if (state_ff == R_DIVN) begin
                  qn_in    = quo_shift;
                  quo_in   = d_ff;
                  rem_in   = '0;
                  cnt_in   = CW'(NW - 1);
                  state_in = R_DIVD;
               end else begin
                  qd_in    = quo_shift;
                  done_in  = 1'b1;
                  state_in = R_IDLE;
               end
            end
         end
         default: state_in = R_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= R_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      u_ff   <= u_in;
      v_ff   <= v_in;
      g_ff   <= g_in;
      n_ff   <= n_in;
      d_ff   <= d_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      qn_ff  <= qn_in;
      qd_ff  <= qd_in;
      k_ff   <= k_in;
      cnt_ff <= cnt_in;
   end

   assign done  = done_ff;
   assign q_num = qn_ff;
   assign q_den = qd_ff;

endmodule

>>> design/rational_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// rational_arithmetic_unit: add, subtract, multiply, divide or compare two
// signed fractions and return the result reduced to lowest terms.
// The unit works on one beat at a time and holds req_stall high until the
// result is in the output register. A compare forms its cross products and
// combines them, then goes to the output register; an error or unused mode
// goes straight to it. An arithmetic beat forms the three cross products and
// the combine, then runs the binary GCD (a swap and a subtract per bit removed
// in the worst case), the two divisions by the GCD and the hand-off of the
// quotients to the output register; when the result numerator is zero the
// GCD and the divisions are skipped. The reduction engine has a single
// subtractor, which takes one GCD step or one quotient bit per cycle. In
// arithmetic modes the result sign sits on the numerator, the denominator is
// positive and a zero result is 0/1; other beats return zero in both fields.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit #(
   parameter int unsigned OPERAND_BITS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [2:0]                       req_mode,
   input  logic signed [OPERAND_BITS-1:0]   req_num_a,
   input  logic signed [OPERAND_BITS-1:0]   req_den_a,
   input  logic signed [OPERAND_BITS-1:0]   req_num_b,
   input  logic signed [OPERAND_BITS-1:0]   req_den_b,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic signed [2*OPERAND_BITS:0]   rsp_res_num,
   output logic [2*OPERAND_BITS-2:0]        rsp_res_den,
   output logic [1:0]                       rsp_order,
   output logic [1:0]                       rsp_status
);

   import rau_pkg::*;

   localparam int unsigned W  = OPERAND_BITS;
   localparam int unsigned NW = 2 * OPERAND_BITS;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MUL1 = 3'd1;
   localparam logic [2:0] ST_MUL2 = 3'd2;
   localparam logic [2:0] ST_MUL3 = 3'd3;
   localparam logic [2:0] ST_COMB = 3'd4;
   localparam logic [2:0] ST_RED  = 3'd5;
   localparam logic [2:0] ST_DONE = 3'd6;

   logic [2:0]    state_ff, state_in;
   logic [2:0]    mode_ff, mode_in;
   logic [W-1:0]  mna_ff, mna_in;
   logic [W-1:0]  mda_ff, mda_in;
   logic [W-1:0]  mnb_ff, mnb_in;
   logic [W-1:0]  mdb_ff, mdb_in;
   logic          sgna_ff, sgna_in;
   logic          sgnb_ff, sgnb_in;
   logic [NW-1:0] p1_ff, p1_in;
   logic [NW-1:0] p2_ff, p2_in;
   logic          neg_ff, neg_in;
   logic          arith_ff, arith_in;
   logic [1:0]    ord_ff, ord_in;
   logic [1:0]    stat_ff, stat_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [NW:0]   rsp_res_num_ff, rsp_res_num_in;
   logic [NW-2:0] rsp_res_den_ff, rsp_res_den_in;
   logic [1:0]    rsp_order_ff, rsp_order_in;
   logic [1:0]    rsp_status_ff, rsp_status_in;

   logic          accept;
   logic          out_free;
   logic [W-1:0]  mul_a, mul_b;
   logic [NW-1:0] prod;
   logic [NW:0]   term1, term2, comb_sum, comb_abs, q_ext;
   logic          rdc_start, rdc_done;
   logic [NW-1:0] rdc_num, rdc_den, q_num, q_den;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Cross-product schedule; mode picks which magnitudes meet in each cycle.
   always_comb begin
      mul_a = mna_ff;
      mul_b = mdb_ff;
      unique case (state_ff)
         ST_MUL1: begin
            mul_a = mna_ff;
            mul_b = (mode_ff == MODE_MUL) ? mnb_ff : mdb_ff;
         end
         ST_MUL2: begin
            mul_a = mnb_ff;
            mul_b = mda_ff;
         end
         ST_MUL3: begin
            mul_a = mda_ff;
            mul_b = (mode_ff == MODE_DIV) ? mnb_ff : mdb_ff;
         end
         default: begin
            mul_a = mna_ff;
            mul_b = mdb_ff;
         end
      endcase
   end

   rau_mult #(
      .WIDTH (W)
   ) u_mult (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (prod)
   );

   // Signed cross terms for add, subtract and compare.
   assign term1 = sgna_ff ? (~{1'b0, p1_ff} + 1'b1) : {1'b0, p1_ff};
   assign term2 = sgnb_ff ? (~{1'b0, p2_ff} + 1'b1) : {1'b0, p2_ff};

   always_comb begin
      case (mode_ff)
         MODE_ADD: comb_sum = term1 + term2;
         default:  comb_sum = term1 - term2;
      endcase
   end

   assign comb_abs = comb_sum[NW] ? (~comb_sum + 1'b1) : comb_sum;

   always_comb begin
      if ((mode_ff == MODE_ADD) || (mode_ff == MODE_SUB)) begin
         rdc_num = comb_abs[NW-1:0];
      end else begin
         rdc_num = p1_ff;
      end
   end

   assign rdc_den   = prod;
   assign rdc_start = (state_ff == ST_COMB) && (mode_ff != MODE_CMP);

   rau_reduce #(
      .NW (NW)
   ) u_reduce (
      .clock   (clock),
      .reset   (reset),
      .start   (rdc_start),
      .num_mag (rdc_num),
      .den_mag (rdc_den),
      .done    (rdc_done),
      .q_num   (q_num),
      .q_den   (q_den)
   );

   assign q_ext = (neg_ff && (q_num != '0)) ? (~{1'b0, q_num} + 1'b1) : {1'b0, q_num};

   always_comb begin
      state_in       = state_ff;
      mode_in        = mode_ff;
      mna_in         = mna_ff;
      mda_in         = mda_ff;
      mnb_in         = mnb_ff;
      mdb_in         = mdb_ff;
      sgna_in        = sgna_ff;
      sgnb_in        = sgnb_ff;
      p1_in          = p1_ff;
      p2_in          = p2_ff;
      neg_in         = neg_ff;
      arith_in       = arith_ff;
      ord_in         = ord_ff;
      stat_in        = stat_ff;
      rsp_res_num_in = rsp_res_num_ff;
      rsp_res_den_in = rsp_res_den_ff;
      rsp_order_in   = rsp_order_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_valid_in   = rsp_stall ? rsp_valid_ff : 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               // Denominators are made positive by folding their signs
               // into the numerator signs.
               mode_in  = req_mode;
               mna_in   = req_num_a[W-1] ? (~req_num_a + 1'b1) : req_num_a;
               mda_in   = req_den_a[W-1] ? (~req_den_a + 1'b1) : req_den_a;
               mnb_in   = req_num_b[W-1] ? (~req_num_b + 1'b1) : req_num_b;
               mdb_in   = req_den_b[W-1] ? (~req_den_b + 1'b1) : req_den_b;
               sgna_in  = req_num_a[W-1] ^ req_den_a[W-1];
               sgnb_in  = req_num_b[W-1] ^ req_den_b[W-1];
               ord_in   = ORD_EQUAL;
               stat_in  = STAT_OK;
               arith_in = 1'b0;
               if (req_mode > MODE_CMP) begin
                  state_in = ST_DONE;
               end else if ((req_den_a == '0) || (req_den_b == '0)) begin
                  stat_in  = STAT_DEN_ZERO;
                  state_in = ST_DONE;
               end else if ((req_mode == MODE_DIV) && (req_num_b == '0)) begin
                  stat_in  = STAT_DIV_ZERO;
                  state_in = ST_DONE;
               end else begin
                  arith_in = (req_mode != MODE_CMP);
                  state_in = ST_MUL1;
               end
            end
         end
         ST_MUL1: state_in = ST_MUL2;
         ST_MUL2: begin
            p1_in    = prod;
            state_in = ST_MUL3;
         end
         ST_MUL3: begin
            p2_in    = prod;
            state_in = ST_COMB;
         end
         ST_COMB: begin
            case (mode_ff) inside
               MODE_CMP: begin
                  if (comb_sum == '0) begin
                     ord_in = ORD_EQUAL;
                  end else if (comb_sum[NW]) begin
                     ord_in = ORD_LESS;
                  end else begin
                     ord_in = ORD_GREATER;
                  end
               end
               MODE_ADD, MODE_SUB: neg_in = comb_sum[NW];
               MODE_MUL:           neg_in = sgna_ff ^ sgnb_ff;
               default:            neg_in = sgna_ff ^ sgnb_ff;
            endcase
            state_in = (mode_ff == MODE_CMP) ? ST_DONE : ST_RED;
         end
         ST_RED: begin
            if (rdc_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_res_num_in = arith_ff ? q_ext : '0;
               rsp_res_den_in = arith_ff ? q_den[NW-2:0] : '0;
               rsp_order_in   = ord_ff;
               rsp_status_in  = stat_ff;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff        <= mode_in;
      mna_ff         <= mna_in;
      mda_ff         <= mda_in;
      mnb_ff         <= mnb_in;
      mdb_ff         <= mdb_in;
      sgna_ff        <= sgna_in;
      sgnb_ff        <= sgnb_in;
      p1_ff          <= p1_in;
      p2_ff          <= p2_in;
      neg_ff         <= neg_in;
      arith_ff       <= arith_in;
      ord_ff         <= ord_in;
      stat_ff        <= stat_in;
      rsp_res_num_ff <= rsp_res_num_in;
      rsp_res_den_ff <= rsp_res_den_in;
      rsp_order_ff   <= rsp_order_in;
      rsp_status_ff  <= rsp_status_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_res_num = $signed(rsp_res_num_ff);
   assign rsp_res_den = rsp_res_den_ff;
   assign rsp_order   = rsp_order_ff;
   assign rsp_status  = rsp_status_ff;

endmodule
